// ===== sv/rrs_pkg.sv =====
// rrs_pkg: constants, codes, record type and time helpers of the round-robin scheduler
// no dependencies; imported by the channel interfaces, the ready ring and the top level
`timescale 1ns / 1ps

package rrs_pkg;

  // sizing
  localparam int MAX_PROCS = 16;
  localparam int FRAC_BITS = 8;
  localparam int IDX_W     = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);
  localparam int TIME_W    = 32;
  localparam int ID_W      = 8;
  localparam int CMD_W     = 2;
  localparam int KIND_W    = 3;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 32;

  localparam logic [TIME_W-1:0] TIME_MAX     = '1;
  localparam logic [TIME_W-1:0] QUANTUM_RST  = TIME_W'(1) << FRAC_BITS;
  localparam logic [TIME_W-1:0] QUANTUM_MIN  = TIME_W'(1);
  localparam logic [CNT_W-1:0]  CNT_FULL     = CNT_W'(MAX_PROCS);
  localparam logic [IDX_W-1:0]  IDX_LAST     = IDX_W'(MAX_PROCS - 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIME_QUANTUM = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SWITCH_COST  = CFG_IDX_W'(1);

  // input commands
  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_STEP  = 2'd1,
    CMD_CLEAR = 2'd2
  } cmd_t;

  // result record kinds
  typedef enum logic [KIND_W-1:0] {
    REC_SLICE    = 3'd0,
    REC_SWITCH   = 3'd1,
    REC_FINISH   = 3'd2,
    REC_ALL_DONE = 3'd3,
    REC_REJECT   = 3'd4
  } kind_t;

  // sequencer states
  typedef enum logic [3:0] {
    S_IDLE,
    S_REJECT,
    S_INSERT,
    S_ADMIT,
    S_ALL_DONE,
    S_POP,
    S_RUN_A,
    S_RUN_B,
    S_SLICE,
    S_FINISH,
    S_SWITCH
  } state_t;

  // one result record
  typedef struct packed {
    kind_t             record_kind;
    logic [ID_W-1:0]   out_proc_id;
    logic [TIME_W-1:0] start_time;
    logic [TIME_W-1:0] end_time;
    logic [TIME_W-1:0] first_start;
    logic              last_of_step;
  } rec_t;

  // ready ring controls
  typedef struct packed {
    logic push;
    logic pop;
    logic clr;
  } ring_ctl_t;

  // saturating time addition
  function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0] a,
                                                input logic [TIME_W-1:0] b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? TIME_MAX : s[TIME_W-1:0];
  endfunction

endpackage

// ===== sv/rrs_channels.sv =====
// rrs_channels: valid/ready interfaces of the request channel and the record channel
// depends on rrs_pkg for field widths and the record kind type
`timescale 1ns / 1ps

interface rrs_in_if import rrs_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [ID_W-1:0]   proc_id;
  logic [TIME_W-1:0] arrival_time;
  logic [TIME_W-1:0] burst_time;

  modport source (output valid, command, proc_id, arrival_time, burst_time, input ready);
  modport sink   (input valid, command, proc_id, arrival_time, burst_time, output ready);
endinterface

interface rrs_out_if import rrs_pkg::*; ();
  logic              valid;
  logic              ready;
  kind_t             record_kind;
  logic [ID_W-1:0]   out_proc_id;
  logic [TIME_W-1:0] start_time;
  logic [TIME_W-1:0] end_time;
  logic [TIME_W-1:0] first_start;
  logic              last_of_step;

  modport source (output valid, record_kind, out_proc_id, start_time, end_time,
                  first_start, last_of_step, input ready);
  modport sink   (input valid, record_kind, out_proc_id, start_time, end_time,
                  first_start, last_of_step, output ready);
endinterface

// ===== sv/rrs_ready_ring.sv =====
// rrs_ready_ring: FIFO ring of table indexes waiting to run
// depends on rrs_pkg for sizing and the control struct
`timescale 1ns / 1ps

module rrs_ready_ring import rrs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  ring_ctl_t        ctl,
  input  logic [IDX_W-1:0] push_idx,
  output logic [IDX_W-1:0] head_idx,
  output logic [CNT_W-1:0] count
);

  logic [IDX_W-1:0] ring_r [MAX_PROCS];
  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  // push is dropped when full
  assign do_push = ctl.push && (count_r != CNT_FULL);
  assign do_pop  = ctl.pop && (count_r != '0);

  // pointer and count update
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.clr) begin
      head_nxt  = '0;
      tail_nxt  = '0;
      count_nxt = '0;
    end else begin
      if (do_push) tail_nxt = (tail_r == IDX_LAST) ? '0 : tail_r + IDX_W'(1);
      if (do_pop)  head_nxt = (head_r == IDX_LAST) ? '0 : head_r + IDX_W'(1);
      if (do_push && !do_pop) count_nxt = count_r + CNT_W'(1);
      else if (do_pop && !do_push) count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // ring storage
  always_ff @(posedge clk) begin
    if (do_push && !ctl.clr) ring_r[tail_r] <= push_idx;
  end

  assign head_idx = ring_r[head_r];
  assign count    = count_r;

endmodule

// ===== sv/round_robin_scheduler_unit.sv =====
// round_robin_scheduler_unit: top level, sequencer, process table and record register
// depends on rrs_pkg, rrs_channels (rrs_in_if, rrs_out_if) and rrs_ready_ring
`timescale 1ns / 1ps

// Round-robin scheduler. Load requests insert a process into a 16-entry table kept in
// arrival order; step requests dispatch one time slice and give one to three records
// (slice, completion, context switch), or one all-done record; clear empties everything.
// One request is in work at a time and in_ch.ready is high only while the sequencer is
// idle. A load moves each entry with a later arrival up one place, then writes the new
// entry. A step admits the processes that have arrived, jumping over idle time, and
// gives its records as the output register frees; a rejected request gives one reject
// record. The sequencer walks the table one entry per cycle through one shared read
// port for both insertion and admission, then works out the slice in S_POP, S_RUN_A
// and S_RUN_B. A finished record waits in the output register while the next request
// is taken.

module round_robin_scheduler_unit import rrs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  rrs_in_if.sink               in_ch,
  rrs_out_if.source            out_ch,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  // configuration registers
  logic [TIME_W-1:0] quantum_r, cost_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      quantum_r <= QUANTUM_RST;
      cost_r    <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIME_QUANTUM: quantum_r <= cfg_wdata;
        REG_SWITCH_COST:  cost_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // process table
  logic [ID_W-1:0]   tbl_id_r      [MAX_PROCS];
  logic [TIME_W-1:0] tbl_arr_r     [MAX_PROCS];
  logic [TIME_W-1:0] tbl_rem_r     [MAX_PROCS];
  logic [TIME_W-1:0] tbl_fs_r      [MAX_PROCS];
  logic              tbl_started_r [MAX_PROCS];

  // sequencer and counters
  state_t            state_r, state_nxt;
  logic [ID_W-1:0]   pid_r;
  logic [TIME_W-1:0] arr_r, burst_r;
  logic [CNT_W-1:0]  pos_r, loaded_r, admitted_r, completed_r;
  logic [IDX_W-1:0]  idx_r;
  logic [TIME_W-1:0] exec_r, start_r, now_r;
  logic              done_r, running_r;

  // output register
  rec_t              out_rec_r, emit_rec;
  logic              out_valid_r;

  // ready ring
  ring_ctl_t         ring_ctl;
  logic [IDX_W-1:0]  ring_push_idx, ring_head;
  logic [CNT_W-1:0]  ring_count;

  rrs_ready_ring u_ring (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ring_ctl),
    .push_idx (ring_push_idx),
    .head_idx (ring_head),
    .count    (ring_count)
  );

  // shared table read port
  logic [IDX_W-1:0]  pos_m1, arr_addr, ent_addr;
  logic [TIME_W-1:0] rd_arr, rd_rem, quantum_eff;
  logic              in_fire, slot_free, sw_need, admit_ok;

  assign pos_m1   = IDX_W'(pos_r - CNT_W'(1));
  assign arr_addr = (state_r == S_INSERT) ? pos_m1 : admitted_r[IDX_W-1:0];
  assign ent_addr = (state_r == S_INSERT) ? pos_m1 : idx_r;
  assign rd_arr   = tbl_arr_r[arr_addr];
  assign rd_rem   = tbl_rem_r[ent_addr];

  assign quantum_eff = (quantum_r == '0) ? QUANTUM_MIN : quantum_r;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign slot_free   = !out_valid_r || out_ch.ready;
  assign admit_ok    = (admitted_r < loaded_r) && (rd_arr <= now_r);
  assign sw_need     = (cost_r != '0) && (completed_r < loaded_r) && (ring_count != '0);

  // strobes from the sequencer
  logic st_load, st_step, st_clear, ins_shift, ins_write;
  logic adm_push, adm_jump, do_pop, run_a, run_b, emit, sw_emit;

  // next state and outputs
  always_comb begin
    state_nxt = state_r;
    st_load   = 1'b0;
    st_step   = 1'b0;
    st_clear  = 1'b0;
    ins_shift = 1'b0;
    ins_write = 1'b0;
    adm_push  = 1'b0;
    adm_jump  = 1'b0;
    do_pop    = 1'b0;
    run_a     = 1'b0;
    run_b     = 1'b0;
    emit      = 1'b0;
    sw_emit   = 1'b0;
    emit_rec  = '{record_kind: REC_REJECT, out_proc_id: '0, start_time: '0,
                  end_time: '0, first_start: '0, last_of_step: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          case (in_ch.command)
            CMD_LOAD: begin
              if (running_r || loaded_r == CNT_FULL) state_nxt = S_REJECT;
              else begin
                st_load   = 1'b1;
                state_nxt = S_INSERT;
              end
            end
            CMD_STEP: begin
              st_step   = 1'b1;
              state_nxt = S_ADMIT;
            end
            CMD_CLEAR: st_clear = 1'b1;
            default:   state_nxt = S_REJECT;
          endcase
        end
      end
      S_REJECT: begin
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // move later arrivals up one place, then write the new entry
      S_INSERT: begin
        if (pos_r != '0 && rd_arr > arr_r) ins_shift = 1'b1;
        else begin
          ins_write = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      // admit arrived processes, jump over idle time
      S_ADMIT: begin
        if (admit_ok) adm_push = 1'b1;
        else if (ring_count != '0) state_nxt = S_POP;
        else if (admitted_r >= loaded_r) state_nxt = S_ALL_DONE;
        else adm_jump = 1'b1;
      end
      S_ALL_DONE: begin
        emit_rec.record_kind = REC_ALL_DONE;
        emit_rec.start_time  = now_r;
        emit_rec.end_time    = now_r;
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_POP: begin
        do_pop    = 1'b1;
        state_nxt = S_RUN_A;
      end
      S_RUN_A: begin
        run_a     = 1'b1;
        state_nxt = S_RUN_B;
      end
      S_RUN_B: begin
        run_b     = 1'b1;
        state_nxt = S_SLICE;
      end
      S_SLICE: begin
        emit_rec.record_kind  = REC_SLICE;
        emit_rec.out_proc_id  = tbl_id_r[idx_r];
        emit_rec.start_time   = start_r;
        emit_rec.end_time     = now_r;
        emit_rec.last_of_step = !done_r && !sw_need;
        if (slot_free) begin
          emit = 1'b1;
          if (done_r) state_nxt = S_FINISH;
          else if (sw_need) state_nxt = S_SWITCH;
          else state_nxt = S_IDLE;
        end
      end
      S_FINISH: begin
        emit_rec.record_kind  = REC_FINISH;
        emit_rec.out_proc_id  = tbl_id_r[idx_r];
        emit_rec.end_time     = now_r;
        emit_rec.first_start  = tbl_fs_r[idx_r];
        emit_rec.last_of_step = !sw_need;
        if (slot_free) begin
          emit      = 1'b1;
          state_nxt = sw_need ? S_SWITCH : S_IDLE;
        end
      end
      S_SWITCH: begin
        emit_rec.record_kind = REC_SWITCH;
        emit_rec.start_time  = now_r;
        emit_rec.end_time    = sat_add(now_r, cost_r);
        if (slot_free) begin
          emit      = 1'b1;
          sw_emit   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  // ring controls
  assign ring_ctl.push  = adm_push || (run_b && (rd_rem == exec_r) == 1'b0);
  assign ring_ctl.pop   = do_pop;
  assign ring_ctl.clr   = st_clear;
  assign ring_push_idx  = adm_push ? admitted_r[IDX_W-1:0] : idx_r;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // control counters and time
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r    <= '0;
      admitted_r  <= '0;
      completed_r <= '0;
      now_r       <= '0;
      running_r   <= 1'b0;
    end else begin
      if (st_clear) begin
        loaded_r    <= '0;
        admitted_r  <= '0;
        completed_r <= '0;
        now_r       <= '0;
        running_r   <= 1'b0;
      end
      if (st_step)   running_r  <= 1'b1;
      if (ins_write) loaded_r   <= loaded_r + CNT_W'(1);
      if (adm_push)  admitted_r <= admitted_r + CNT_W'(1);
      if (adm_jump)  now_r      <= rd_arr;
      if (run_b) begin
        now_r <= sat_add(now_r, exec_r);
        if (rd_rem == exec_r) completed_r <= completed_r + CNT_W'(1);
      end
      if (sw_emit)   now_r      <= emit_rec.end_time;
    end
  end

  // request fields and slice working registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      pid_r   <= in_ch.proc_id;
      arr_r   <= in_ch.arrival_time;
      burst_r <= in_ch.burst_time;
    end
    if (st_load)   pos_r <= loaded_r;
    if (ins_shift) pos_r <= pos_r - CNT_W'(1);
    if (do_pop)    idx_r <= ring_head;
    if (run_a) begin
      exec_r  <= (quantum_eff < rd_rem) ? quantum_eff : rd_rem;
      start_r <= now_r;
    end
    if (run_b)     done_r <= (rd_rem == exec_r);
  end

  // table payload
  always_ff @(posedge clk) begin
    if (ins_shift) begin
      tbl_id_r[pos_r[IDX_W-1:0]]  <= tbl_id_r[pos_m1];
      tbl_arr_r[pos_r[IDX_W-1:0]] <= rd_arr;
      tbl_rem_r[pos_r[IDX_W-1:0]] <= rd_rem;
    end
    if (ins_write) begin
      tbl_id_r[pos_r[IDX_W-1:0]]  <= pid_r;
      tbl_arr_r[pos_r[IDX_W-1:0]] <= arr_r;
      tbl_rem_r[pos_r[IDX_W-1:0]] <= burst_r;
      tbl_fs_r[pos_r[IDX_W-1:0]]  <= '0;
    end
    if (run_a && !tbl_started_r[idx_r]) tbl_fs_r[idx_r] <= now_r;
    if (run_b) tbl_rem_r[idx_r] <= rd_rem - exec_r;
  end

  // started flags
  always_ff @(posedge clk) begin
    if (!rst_n || st_clear) begin
      for (int i = 0; i < MAX_PROCS; i++) tbl_started_r[i] <= 1'b0;
    end else begin
      if (ins_write) tbl_started_r[pos_r[IDX_W-1:0]] <= 1'b0;
      if (run_a)     tbl_started_r[idx_r] <= 1'b1;
    end
  end

  // output record register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (emit) out_valid_r <= 1'b1;
    else if (out_ch.ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (emit) out_rec_r <= emit_rec;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.record_kind  = out_rec_r.record_kind;
  assign out_ch.out_proc_id  = out_rec_r.out_proc_id;
  assign out_ch.start_time   = out_rec_r.start_time;
  assign out_ch.end_time     = out_rec_r.end_time;
  assign out_ch.first_start  = out_rec_r.first_start;
  assign out_ch.last_of_step = out_rec_r.last_of_step;

  // invariants of counters and sequencing
  a_admit_le_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    admitted_r <= loaded_r && loaded_r <= CNT_FULL)
    else $error("admitted count exceeds loaded count");

  a_ring_le_admitted: assert property (@(posedge clk) disable iff (!rst_n)
    ring_count <= admitted_r)
    else $error("ready ring holds more entries than were admitted");

  a_step_sets_running: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_ch.command == CMD_STEP |=> running_r)
    else $error("step request did not mark the scheduler running");

  a_no_emit_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> !emit || $past(emit) == 1'b0 || out_valid_r)
    else $error("record written over a pending record");

endmodule
